// ===== rtl/framed_packet_crc_receiver_top_macros.svh =====
// Assertion shorthands used by the checker file.
// Each expects signals named clk and arst_n in the enclosing scope.
`ifndef FRAMED_PACKET_CRC_RECEIVER_TOP_MACROS_SVH
`define FRAMED_PACKET_CRC_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FPCR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpcr assertion failed");

// Next-cycle implication, checked out of reset.
`define FPCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpcr assertion failed");

`endif

// ===== rtl/fpcr_pkg.sv =====
package fpcr_pkg;

	// Frame markers
	localparam logic [7:0] MARK_SOH = 8'h01;
	localparam logic [7:0] MARK_STX = 8'h02;
	localparam logic [7:0] MARK_ETX = 8'h03;
	localparam logic [7:0] MARK_EOT = 8'h04;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_PAYLOAD = 3'd1,
		ST_GOOD    = 3'd2,
		ST_BAD     = 3'd3,
		ST_ABORT   = 3'd4
	} status_t;

	// One result beat
	typedef struct packed {
		status_t    status;
		logic [7:0] payload_byte;
		logic [7:0] frame_length;
	} result_t;

endpackage

// ===== rtl/fpcr_rx_if.sv =====
interface fpcr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/fpcr_res_if.sv =====
interface fpcr_res_if;
	logic              valid;
	logic              ready;
	fpcr_pkg::status_t status;
	logic [7:0]        payload_byte;
	logic [7:0]        frame_length;

	modport source (output valid, output status, output payload_byte, output frame_length,
		input ready);
	modport sink   (input valid, input status, input payload_byte, input frame_length,
		output ready);
endinterface

// ===== rtl/fpcr_crc_byte.sv =====
module fpcr_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import fpcr_pkg::*;

	// Fold one byte in, LSB first, reflected polynomial
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

// ===== rtl/fpcr_parser.sv =====
module fpcr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        rx_byte,
	output fpcr_pkg::result_t result
);
	import fpcr_pkg::*;

	logic [8:0]  pos_q;
	logic [7:0]  len_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_hi_q;
	logic [7:0]  crc_lo_q;

	logic [8:0]  etx_pos;
	logic [15:0] crc_next;
	logic [8:0]  pos_d;
	logic [7:0]  len_d;
	logic [15:0] crc_d;
	logic [7:0]  crc_hi_d;
	logic [7:0]  crc_lo_d;

	fpcr_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	assign etx_pos = {1'b0, len_q} + 9'd3;

	// Decode the byte against the frame position
	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		crc_lo_d = crc_lo_q;
		result   = '{status: ST_NONE, payload_byte: 8'h00, frame_length: 8'h00};
		if (pos_q == 9'd0) begin
			if (rx_byte == MARK_SOH) begin
				pos_d = 9'd1;
			end
		end else if (pos_q == 9'd1) begin
			len_d = rx_byte;
			if (rx_byte == 8'h00) begin
				pos_d         = 9'd0;
				result.status = ST_ABORT;
			end else begin
				pos_d = 9'd2;
			end
		end else if (pos_q == 9'd2) begin
			if (rx_byte == MARK_STX) begin
				crc_d = CRC_INIT;
				pos_d = 9'd3;
			end else begin
				pos_d         = 9'd0;
				result.status = ST_ABORT;
			end
		end else if (pos_q < etx_pos) begin
			crc_d               = crc_next;
			result.status       = ST_PAYLOAD;
			result.payload_byte = rx_byte;
			pos_d               = pos_q + 9'd1;
		end else if (pos_q == etx_pos) begin
			if (rx_byte == MARK_ETX) begin
				pos_d = pos_q + 9'd1;
			end else begin
				pos_d         = 9'd0;
				result.status = ST_ABORT;
			end
		end else if (pos_q == etx_pos + 9'd1) begin
			crc_hi_d = rx_byte;
			pos_d    = pos_q + 9'd1;
		end else if (pos_q == etx_pos + 9'd2) begin
			crc_lo_d = rx_byte;
			pos_d    = pos_q + 9'd1;
		end else if (pos_q == etx_pos + 9'd3 && rx_byte == MARK_EOT) begin
			result.status       = ({crc_hi_q, crc_lo_q} == crc_q) ? ST_GOOD : ST_BAD;
			result.frame_length = len_q;
			pos_d               = 9'd0;
		end else begin
			pos_d         = 9'd0;
			result.status = ST_ABORT;
		end
	end

	// Advance frame state on each consumed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 9'd0;
			len_q    <= 8'h00;
			crc_q    <= CRC_INIT;
			crc_hi_q <= 8'h00;
			crc_lo_q <= 8'h00;
		end else if (en) begin
			pos_q    <= pos_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

// ===== rtl/framed_packet_crc_receiver_top.sv =====
// Framed packet receiver: takes one serial byte per beat on rx and returns exactly one
// result beat on res for every byte, in order. Frames are SOH, length (1..255), STX,
// payload, ETX, CRC high, CRC low, EOT; payload bytes come out as they arrive (status 1,
// tentative), and EOT gives frame good (2) or CRC mismatch (3) with the length. A byte
// that breaks the layout gives a framing abort (4) and returns to idle; idle ignores
// everything but SOH (status 0). Throughput is one byte per clock with no gaps while
// res is ready. The byte lands in the input register when rx accepts it and moves into
// the result register when the output stage advances; res valid rises with that load.
// The cycle time is set by the byte-wide CRC-16/MODBUS update and the frame position
// compare between those two registers. Backpressure on res stalls both stages.
module framed_packet_crc_receiver_top (
	input logic       clk,
	input logic       arst_n,
	fpcr_rx_if.sink   rx,
	fpcr_res_if.source res
);
	import fpcr_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       v_s2;
	result_t    res_s2;
	result_t    parsed;
	logic       adv;

	// Stage 2 moves when empty or drained
	assign adv      = !v_s2 || res.ready;
	assign rx.ready = !v_s1 || adv;

	fpcr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (v_s1 && adv),
		.rx_byte (byte_s1),
		.result  (parsed)
	);

	// Capture input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= parsed;
		end
	end

	assign res.valid        = v_s2;
	assign res.status       = res_s2.status;
	assign res.payload_byte = res_s2.payload_byte;
	assign res.frame_length = res_s2.frame_length;

endmodule

// ===== rtl/fpcr_checker.sv =====
`include "framed_packet_crc_receiver_top_macros.svh"

module fpcr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [7:0] payload_byte,
	input logic [7:0] frame_length
);
	import fpcr_pkg::*;

	// Empty output side never blocks input
	`FPCR_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

	// Payload byte only rides with a payload status
	`FPCR_ASSERT_NOW(a_payload_zero, out_valid && status != ST_PAYLOAD, payload_byte == 8'h00)

	// Length only rides with a verdict
	`FPCR_ASSERT_NOW(a_length_zero,
		out_valid && status != ST_GOOD && status != ST_BAD, frame_length == 8'h00)

	// Stalled result stays up
	`FPCR_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(status))

endmodule

bind framed_packet_crc_receiver_top fpcr_checker u_fpcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (rx.ready),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.status       (res.status),
	.payload_byte (res.payload_byte),
	.frame_length (res.frame_length)
);

// ===== dv/framed_packet_crc_receiver_top_tb.sv =====
module framed_packet_crc_receiver_top_tb;
	import fpcr_pkg::*;

	localparam int IDLE_PCT = 47;
	localparam int BOTH_PCT = 16;
	localparam int ITEMS_PER_PHASE = 350;

	logic clk;
	logic arst_n;

	fpcr_rx_if  rx_if ();
	fpcr_res_if res_if ();

	framed_packet_crc_receiver_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	// Bytes still to send, and the results those already sent must produce
	logic [7:0] byte_stream[$];
	result_t    awaited_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;

	// Own copy of the frame decoder state
	logic [8:0]  frame_pos = 9'd0;
	logic [7:0]  frame_len = 8'd0;
	logic [15:0] frame_crc = CRC_INIT;
	logic [7:0]  crc_hi_seen = 8'd0;
	logic [7:0]  crc_lo_seen = 8'd0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Fold one byte into a CRC-16/MODBUS
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Advance the decoder by one received byte and return the result it gives
	function automatic result_t decode_rx_byte(input logic [7:0] b);
		result_t    r;
		logic [8:0] etx_pos;
		r.status = ST_NONE;
		r.payload_byte = 8'h00;
		r.frame_length = 8'h00;
		etx_pos = 9'd3 + {1'b0, frame_len};
		if (frame_pos == 9'd0) begin
			if (b == MARK_SOH)
				frame_pos = 9'd1;
		end else if (frame_pos == 9'd1) begin
			frame_len = b;
			if (b == 8'h00) begin
				frame_pos = 9'd0;
				r.status = ST_ABORT;
			end else begin
				frame_pos = 9'd2;
			end
		end else if (frame_pos == 9'd2) begin
			if (b == MARK_STX) begin
				frame_crc = CRC_INIT;
				frame_pos = 9'd3;
			end else begin
				frame_pos = 9'd0;
				r.status = ST_ABORT;
			end
		end else if (frame_pos < etx_pos) begin
			frame_crc = crc16_step(frame_crc, b);
			r.payload_byte = b;
			r.status = ST_PAYLOAD;
			frame_pos = frame_pos + 9'd1;
		end else if (frame_pos == etx_pos) begin
			if (b == MARK_ETX) begin
				frame_pos = frame_pos + 9'd1;
			end else begin
				frame_pos = 9'd0;
				r.status = ST_ABORT;
			end
		end else if (frame_pos == etx_pos + 9'd1) begin
			crc_hi_seen = b;
			frame_pos = frame_pos + 9'd1;
		end else if (frame_pos == etx_pos + 9'd2) begin
			crc_lo_seen = b;
			frame_pos = frame_pos + 9'd1;
		end else if (frame_pos == etx_pos + 9'd3 && b == MARK_EOT) begin
			r.status = (crc_hi_seen == frame_crc[15:8] && crc_lo_seen == frame_crc[7:0]) ?
				ST_GOOD : ST_BAD;
			r.frame_length = frame_len;
			frame_pos = 9'd0;
		end else begin
			frame_pos = 9'd0;
			r.status = ST_ABORT;
		end
		return r;
	endfunction

	// Mostly short frames, some medium, a rare long one (200..255)
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 6);
		else if (r < 98)
			return $urandom_range(7, 40);
		return $urandom_range(200, 255);
	endfunction

	// Queue a complete frame; optionally damage its CRC
	task automatic push_frame(input int len, input bit bad_crc);
		logic [15:0] c;
		logic [7:0]  b;
		c = CRC_INIT;
		byte_stream.push_back(MARK_SOH);
		byte_stream.push_back(len[7:0]);
		byte_stream.push_back(MARK_STX);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			c = crc16_step(c, b);
			byte_stream.push_back(b);
		end
		if (bad_crc)
			c = c ^ (16'h0001 << $urandom_range(0, 15));
		byte_stream.push_back(MARK_ETX);
		byte_stream.push_back(c[15:8]);
		byte_stream.push_back(c[7:0]);
		byte_stream.push_back(MARK_EOT);
	endtask

	// Pick a byte that is not the marker expected; often an SOH to test no restart
	function automatic logic [7:0] wrong_marker(input logic [7:0] mark);
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0 && mark != MARK_SOH)
			return MARK_SOH;
		do
			b = 8'($urandom_range(0, 255));
		while (b == mark);
		return b;
	endfunction

	// Queue a frame that breaks at a length, STX, ETX or EOT slot
	task automatic push_broken_frame(input int len);
		int where;
		where = $urandom_range(0, 3);
		byte_stream.push_back(MARK_SOH);
		if (where == 0) begin
			byte_stream.push_back(8'h00);
		end else begin
			byte_stream.push_back(len[7:0]);
			if (where == 1) begin
				byte_stream.push_back(wrong_marker(MARK_STX));
			end else begin
				byte_stream.push_back(MARK_STX);
				for (int i = 0; i < len; i++)
					byte_stream.push_back(8'($urandom_range(0, 255)));
				if (where == 2) begin
					byte_stream.push_back(wrong_marker(MARK_ETX));
				end else begin
					byte_stream.push_back(MARK_ETX);
					byte_stream.push_back(8'($urandom_range(0, 255)));
					byte_stream.push_back(8'($urandom_range(0, 255)));
					byte_stream.push_back(wrong_marker(MARK_EOT));
				end
			end
		end
	endtask

	// Fill one phase worth of random traffic, idle noise included
	task automatic push_random_phase();
		int counted;
		int start_size;
		int r;
		counted = 0;
		while (counted < ITEMS_PER_PHASE) begin
			start_size = byte_stream.size();
			r = $urandom_range(0, 99);
			if (r < 70) begin
				push_frame(pick_length(), $urandom_range(0, 5) == 0);
			end else if (r < 85) begin
				push_broken_frame(pick_length());
			end else begin
				repeat ($urandom_range(1, 4))
					byte_stream.push_back(8'($urandom_range(0, 255)));
			end
			counted += byte_stream.size() - start_size;
		end
	endtask

	// Hold until everything sent has come back, then let the pipeline settle
	task automatic drain();
		do
			@(negedge clk);
		while (byte_stream.size() != 0 || rx_if.valid || awaited_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Driver: offer the next byte, predict on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= 8'h00;
		end else begin
			if (rx_if.valid && rx_if.ready)
				awaited_results.push_back(decode_rx_byte(rx_if.rx_byte));
			if (!rx_if.valid || rx_if.ready) begin
				if (byte_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					rx_if.valid <= 1'b1;
					rx_if.rx_byte <= byte_stream.pop_front();
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		result_t got;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got.status = res_if.status;
				got.payload_byte = res_if.payload_byte;
				got.frame_length = res_if.frame_length;
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result status %0d byte %0h len %0d",
						$time, got.status, got.payload_byte, got.frame_length);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status || got.payload_byte !== want.payload_byte ||
						got.frame_length !== want.frame_length) begin
						$display("%0t: expected status %0d byte %0h len %0d, got status %0d byte %0h len %0d",
							$time, want.status, want.payload_byte, want.frame_length,
							got.status, got.payload_byte, got.frame_length);
						errors++;
					end
				end
			end
			res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle noise, zero length, SOH in the STX slot, good and bad CRC, bad ETX
		byte_stream.push_back(MARK_ETX);
		byte_stream.push_back(8'h00);
		byte_stream.push_back(MARK_SOH);
		byte_stream.push_back(8'h00);
		byte_stream.push_back(MARK_SOH);
		byte_stream.push_back(8'hFF);
		byte_stream.push_back(MARK_SOH);
		push_frame(1, 1'b0);
		push_frame(1, 1'b1);
		byte_stream.push_back(MARK_SOH);
		byte_stream.push_back(8'h01);
		byte_stream.push_back(MARK_STX);
		byte_stream.push_back(8'hFF);
		byte_stream.push_back(8'hFF);

		// No idling
		push_random_phase();
		drain();

		// Sender gaps
		send_idle_pct = IDLE_PCT;
		push_random_phase();
		drain();

		// Receiver stalls
		send_idle_pct = 0;
		recv_stall_pct = IDLE_PCT;
		push_random_phase();
		drain();

		// Both
		send_idle_pct = BOTH_PCT;
		recv_stall_pct = BOTH_PCT;
		push_random_phase();
		drain();

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpcr_pkg.sv
rtl/fpcr_rx_if.sv
rtl/fpcr_res_if.sv
rtl/fpcr_crc_byte.sv
rtl/fpcr_parser.sv
rtl/framed_packet_crc_receiver_top.sv
rtl/fpcr_checker.sv
dv/framed_packet_crc_receiver_top_tb.sv
